/* hw/rtl/rfc_pkg.sv */
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and helpers for the row FIR convolver
// Widths, the register index codes, the per-item metadata record and the
// coefficient and length helpers used by the top level and its units.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int MAX_TAPS   = 15;
  localparam int NUM_CELLS  = MAX_TAPS;
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int GROUP      = 4;
  localparam int NUM_GROUPS = (NUM_CELLS + GROUP - 1) / GROUP;
  localparam int PART_W     = PROD_W + 2;
  localparam int VALUE_W    = 36;
  localparam int COL_W      = 12;
  localparam int LEN_W      = 13;
  localparam int TAPS_W     = 4;
  localparam int RAD_W      = 3;
  localparam int REM_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_COLS   = 4096;
  localparam int MAX_ROWS   = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH,
    REG_IMAGE_ROWS,
    REG_KERNEL_TAPS,
    REG_COEF_0_3,
    REG_COEF_4_7,
    REG_COEF_8_11,
    REG_COEF_12_14
  } cfg_reg_t;

  typedef logic [NUM_CELLS-1:0][COEF_W-1:0] tap_bank_t;

  // Burst description carried down the pipe with each request
  typedef struct packed {
    logic [COL_W-1:0] first_col;  // column of the first result
    logic [REM_W-1:0] rem;        // results after the first one
    logic             nz;         // first result carries the dot product
    logic             row_last;   // request was the last pixel of its row
    logic             img_last;   // ... and of the image
  } meta_t;

  // Last valid index for a programmed length, saturated to 1 .. limit
  function automatic logic [COL_W-1:0] clamp_last(input logic [LEN_W-1:0] v,
                                                  input logic [LEN_W-1:0] limit);
    logic [LEN_W-1:0] t;
    if (v == '0) begin
      t = LEN_W'(1);
    end else if (v > limit) begin
      t = limit;
    end else begin
      t = v;
    end
    return COL_W'(t - LEN_W'(1));
  endfunction

  // Cell m holds the pixel m columns back; it uses tap 2r-m when m <= 2r
  function automatic logic cell_used(input logic [RAD_W-1:0] radius,
                                     input logic [TAPS_W-1:0] m);
    return m <= {radius, 1'b0};
  endfunction

  function automatic logic [COEF_W-1:0] cell_coef(input tap_bank_t taps,
                                                  input logic [RAD_W-1:0] radius,
                                                  input logic [TAPS_W-1:0] m);
    logic [TAPS_W-1:0] k;
    k = {radius, 1'b0} - m;
    if (cell_used(radius, m)) begin
      return taps[k];
    end
    return '0;
  endfunction

endpackage

/* hw/rtl/rfc_cell.sv */
// ----------------------------------------------------------------------------
// rfc_cell: one tap cell of the sample chain
// Holds one window sample, passes it to the next cell on each accepted
// pixel and registers the sample times its tap for the adder tree.
// ----------------------------------------------------------------------------
module rfc_cell (
  input  logic                                 clk,
  input  logic                                 shift_en,
  input  logic                                 cap_en,
  input  logic signed [rfc_pkg::PIX_W-1:0]     sample_in,
  input  logic signed [rfc_pkg::COEF_W-1:0]    coef,
  input  logic                                 used,
  output logic signed [rfc_pkg::PIX_W-1:0]     sample_out,
  output logic        [rfc_pkg::PROD_W-1:0]    product
);

  logic signed [rfc_pkg::PIX_W-1:0]  sample;
  logic signed [rfc_pkg::PROD_W-1:0] prod_c;

  always_comb begin
    prod_c = sample * coef;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample <= sample_in;
    end
    // unused cells give zero so stale samples never reach the sum
    if (cap_en) begin
      product <= used ? prod_c : '0;
    end
  end

  assign sample_out = sample;

endmodule

/* hw/rtl/rfc_sum.sv */
// ----------------------------------------------------------------------------
// rfc_sum: registered adder tree
// Two stages: groups of four products, then the group sums, each stage
// with its own valid bit and request metadata.
// ----------------------------------------------------------------------------
module rfc_sum (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic [rfc_pkg::NUM_CELLS-1:0][rfc_pkg::PROD_W-1:0] products,
  input  logic                                              in_v,
  input  rfc_pkg::meta_t                                    in_meta,
  output logic                                              in_en,
  output logic                                              out_v,
  output rfc_pkg::meta_t                                    out_meta,
  output logic        [rfc_pkg::VALUE_W-1:0]                out_sum,
  input  logic                                              out_en
);

  logic [rfc_pkg::NUM_GROUPS-1:0][rfc_pkg::PART_W-1:0] part;
  logic [rfc_pkg::NUM_GROUPS-1:0][rfc_pkg::PART_W-1:0] part_next;
  logic                                                v3;
  rfc_pkg::meta_t                                      meta3;
  logic [rfc_pkg::VALUE_W-1:0]                         sum_next;
  logic                                                en3;
  logic                                                en4;

  assign en4   = !out_v || out_en;
  assign en3   = !v3 || en4;
  assign in_en = en3;

  always_comb begin
    int idx;
    for (int g = 0; g < rfc_pkg::NUM_GROUPS; g++) begin
      part_next[g] = '0;
      for (int i = 0; i < rfc_pkg::GROUP; i++) begin
        idx = g * rfc_pkg::GROUP + i;
        if (idx < rfc_pkg::NUM_CELLS) begin
          part_next[g] = part_next[g]
            + {{(rfc_pkg::PART_W - rfc_pkg::PROD_W){products[idx][rfc_pkg::PROD_W-1]}},
               products[idx]};
        end
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < rfc_pkg::NUM_GROUPS; g++) begin
      sum_next = sum_next
        + {{(rfc_pkg::VALUE_W - rfc_pkg::PART_W){part[g][rfc_pkg::PART_W-1]}}, part[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en3) begin
        v3 <= in_v;
      end
      if (en4) begin
        out_v <= v3;
      end
    end
    if (en3) begin
      part  <= part_next;
      meta3 <= in_meta;
    end
    if (en4) begin
      out_sum  <= sum_next;
      out_meta <= meta3;
    end
  end

endmodule

/* hw/rtl/rfc_burst.sv */
// ----------------------------------------------------------------------------
// rfc_burst: result emitter and output register
// Turns one request's burst record into one result per cycle while out_stall
// is low: the first column carries the sum when nz is set, the border columns after it carry zero.
// ----------------------------------------------------------------------------
module rfc_burst (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_v,
  input  rfc_pkg::meta_t                        in_meta,
  input  logic        [rfc_pkg::VALUE_W-1:0]    in_sum,
  output logic                                  in_en,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rfc_pkg::VALUE_W-1:0]    value,
  output logic        [rfc_pkg::COL_W-1:0]      out_column,
  output logic                                  row_done,
  output logic                                  image_done,
  output logic                                  last_of_run
);

  logic [rfc_pkg::VALUE_W-1:0] value_q;
  logic [rfc_pkg::COL_W-1:0]   col_q;
  logic [rfc_pkg::REM_W-1:0]   rem_q;
  logic                        row_last_q;
  logic                        img_last_q;
  logic                        fire;
  logic                        free;
  logic                        load;

  assign fire  = out_valid && !out_stall;
  assign free  = !out_valid || (fire && rem_q == '0);
  assign load  = free && in_v;
  assign in_en = free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= in_v;
    end
    if (load) begin
      value_q    <= in_meta.nz ? in_sum : '0;
      col_q      <= in_meta.first_col;
      rem_q      <= in_meta.rem;
      row_last_q <= in_meta.row_last;
      img_last_q <= in_meta.img_last;
    end else if (fire && rem_q != '0) begin
      value_q <= '0;
      col_q   <= col_q + 1'b1;
      rem_q   <= rem_q - 1'b1;
    end
  end

  assign value       = value_q;
  assign out_column  = col_q;
  assign last_of_run = rem_q == '0;
  assign row_done    = row_last_q && rem_q == '0;
  assign image_done  = img_last_q && rem_q == '0;

  a_row_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_done |-> last_of_run)
    else $error("row end not on final result of its request");

  a_image_done_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> row_done)
    else $error("image end off a row end");

  a_border_run: assert property (@(posedge clk) disable iff (rst)
    fire && !last_of_run |=> out_valid && value == '0
                             && out_column == $past(out_column) + 1'b1)
    else $error("border result out of sequence");

endmodule

/* hw/rtl/row_fir_convolve_zero_border_unit.sv */
// ----------------------------------------------------------------------------
// row_fir_convolve_zero_border_unit: row convolver with zero borders
// Odd kernel of up to 15 Q2.14 taps over a raster stream of Q12.4 pixels,
// full precision Q18.18 results, radius columns at each row end give zero.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  ------------------------------------------
//  in       in   in_valid/in_stall   pixel
//  out      out  out_valid/out_stall value, out_column, row_done, image_done,
//                                    last_of_run
//  cfg      in   cfg_we              cfg_index, cfg_data
//
//  One pixel per cycle while in_stall is low. After acceptance a request passes the
//  window shift, products, group sums and final sum registers to the output register.
//  The output register sends one result per cycle while out_stall is low: the last
//  pixel of a row makes up to radius+1 results, so during that burst the pipe can
//  fill and the input stalls.
//  Synchronous reset restores the register defaults and clears the counters
//  and valid bits; the sample chain is not cleared.
//  Stalls ripple back one stage per occupied slot; empty slots let the input
//  keep moving while a result waits at the output.
module row_fir_convolve_zero_border_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // pixel input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rfc_pkg::PIX_W-1:0]       pixel,
  // result output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rfc_pkg::VALUE_W-1:0]     value,
  output logic        [rfc_pkg::COL_W-1:0]       out_column,
  output logic                                   row_done,
  output logic                                   image_done,
  output logic                                   last_of_run,
  // register writes
  input  logic                                   cfg_we,
  input  logic        [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [rfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [rfc_pkg::LEN_W-1:0]  row_length;
  logic [rfc_pkg::LEN_W-1:0]  image_rows;
  logic [rfc_pkg::TAPS_W-1:0] kernel_taps;
  rfc_pkg::tap_bank_t         taps;

  // position in the image
  logic [rfc_pkg::COL_W-1:0] column_count;
  logic [rfc_pkg::COL_W-1:0] row_count;

  // decode of the incoming request
  logic [rfc_pkg::COL_W-1:0] len_last;
  logic [rfc_pkg::COL_W-1:0] rows_last;
  logic [rfc_pkg::RAD_W-1:0] radius;
  logic [rfc_pkg::COL_W-1:0] radius_x;
  logic [rfc_pkg::COL_W-1:0] col_c;
  logic [rfc_pkg::COL_W-1:0] row_c;
  logic                      is_last;
  logic                      is_last_row;
  logic                      has_out;
  rfc_pkg::meta_t            meta_c;

  // pipe control
  logic           accept;
  logic           v1;
  logic           v2;
  logic           en1;
  logic           en2;
  logic           en3;
  logic           v4;
  logic           en4;
  rfc_pkg::meta_t meta1;
  rfc_pkg::meta_t meta2;
  rfc_pkg::meta_t meta4;
  logic [rfc_pkg::VALUE_W-1:0] sum4;

  // cell chain
  logic signed [rfc_pkg::PIX_W-1:0]                         chain [rfc_pkg::NUM_CELLS+1];
  logic [rfc_pkg::NUM_CELLS-1:0][rfc_pkg::PROD_W-1:0]       products;

  // --------------------------------------------------------------------------
  // Register writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length  <= rfc_pkg::LEN_W'(640);
      image_rows  <= rfc_pkg::LEN_W'(480);
      kernel_taps <= rfc_pkg::TAPS_W'(1);
      taps        <= {{((rfc_pkg::NUM_CELLS-1)*rfc_pkg::COEF_W){1'b0}},
                      rfc_pkg::COEF_W'(16384)};  // unit tap 0, Q2.14
    end else if (cfg_we) begin
      unique case (rfc_pkg::cfg_reg_t'(cfg_index))
        rfc_pkg::REG_ROW_LENGTH:  row_length  <= cfg_data[rfc_pkg::LEN_W-1:0];
        rfc_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data[rfc_pkg::LEN_W-1:0];
        rfc_pkg::REG_KERNEL_TAPS: kernel_taps <= cfg_data[rfc_pkg::TAPS_W-1:0];
        rfc_pkg::REG_COEF_0_3:    taps[3:0]   <= cfg_data;
        rfc_pkg::REG_COEF_4_7:    taps[7:4]   <= cfg_data;
        rfc_pkg::REG_COEF_8_11:   taps[11:8]  <= cfg_data;
        rfc_pkg::REG_COEF_12_14:  taps[14:12] <= cfg_data[3*rfc_pkg::COEF_W-1:0];
        default: ;  // index past the register list: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request decode. Only the first result of a request can be nonzero: it is
  // column c-radius, complete once c >= 2*radius. A row's last pixel adds the
  // right-border columns behind it.
  // --------------------------------------------------------------------------
  always_comb begin
    len_last    = rfc_pkg::clamp_last(row_length, rfc_pkg::LEN_W'(rfc_pkg::MAX_COLS));
    rows_last   = rfc_pkg::clamp_last(image_rows, rfc_pkg::LEN_W'(rfc_pkg::MAX_ROWS));
    radius      = kernel_taps[rfc_pkg::TAPS_W-1:1];   // even counts round up
    radius_x    = rfc_pkg::COL_W'(radius);
    // counters past a shortened length act as the last column or row
    col_c       = (column_count > len_last) ? len_last : column_count;
    row_c       = (row_count > rows_last) ? rows_last : row_count;
    is_last     = col_c == len_last;
    is_last_row = row_c == rows_last;
    has_out     = is_last || col_c >= radius_x;

    meta_c.first_col = (col_c >= radius_x) ? col_c - radius_x : '0;
    meta_c.rem       = is_last ? rfc_pkg::REM_W'(col_c - meta_c.first_col) : '0;
    meta_c.nz        = col_c >= {radius_x[rfc_pkg::COL_W-2:0], 1'b0};
    meta_c.row_last  = is_last;
    meta_c.img_last  = is_last && is_last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (is_last) begin
        column_count <= '0;
        row_count    <= is_last_row ? '0 : row_c + 1'b1;
      end else begin
        column_count <= col_c + 1'b1;
        row_count    <= row_c;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipe control: each slot moves when the one ahead is empty or moving.
  // Requests with no result still shift the window but occupy no slot.
  // --------------------------------------------------------------------------
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept && has_out;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
    if (en1) begin
      meta1 <= meta_c;
    end
    if (en2) begin
      meta2 <= meta1;
    end
  end

  // --------------------------------------------------------------------------
  // Sample chain: cell m holds the pixel m columns back and its product
  // --------------------------------------------------------------------------
  assign chain[0] = pixel;

  for (genvar m = 0; m < rfc_pkg::NUM_CELLS; m++) begin : g_cell
    rfc_cell u_cell (
      .clk        (clk),
      .shift_en   (accept),
      .cap_en     (en2),
      .sample_in  (chain[m]),
      .coef       (rfc_pkg::cell_coef(taps, radius, rfc_pkg::TAPS_W'(m))),
      .used       (rfc_pkg::cell_used(radius, rfc_pkg::TAPS_W'(m))),
      .sample_out (chain[m+1]),
      .product    (products[m])
    );
  end

  rfc_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .products (products),
    .in_v     (v2),
    .in_meta  (meta2),
    .in_en    (en3),
    .out_v    (v4),
    .out_meta (meta4),
    .out_sum  (sum4),
    .out_en   (en4)
  );

  rfc_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .in_v        (v4),
    .in_meta     (meta4),
    .in_sum      (sum4),
    .in_en       (en4),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .out_column  (out_column),
    .row_done    (row_done),
    .image_done  (image_done),
    .last_of_run (last_of_run)
  );

  a_col_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !is_last |=> column_count == $past(col_c) + 1'b1)
    else $error("column counter did not advance");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> column_count == '0)
    else $error("column counter did not wrap at row end");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && meta1 == $past(meta1))
    else $error("first slot lost a blocked request");

endmodule
